### src/spmmu_pkg.sv
// Shared constants and types for the paged MMU with bus lock.
// No dependencies; used by smp_page_mmu_with_bus_lock_core.
`default_nettype none

package spmmu_pkg;

  // Default sizing
  localparam int CPU_COUNT_DEF  = 8;
  localparam int PAGE_COUNT_DEF = 64;

  // Field widths fixed by the interface
  localparam int CPU_ID_W  = 3;
  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 7;
  localparam int OFFSET_W  = 12;
  localparam int WIN_PER_CPU = 16;

  // Transaction types
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_IO   = 2'd1;
  localparam logic [1:0] REQ_MEM  = 2'd2;

  // Port 4 read commands (address bits 15..12)
  localparam logic [3:0] CMD_PAGE = 4'd0;
  localparam logic [3:0] CMD_FLAG = 4'd1;
  localparam logic [3:0] CMD_CPU  = 4'd2;

  localparam logic [7:0]       MAP_PORT    = 8'h04;
  localparam logic [7:0]       PREFIX_BYTE = 8'hdd;
  localparam logic [7:0]       FLAG_BASE   = 8'hfc;
  localparam logic [7:0]       BYTE_ONES   = 8'hff;
  localparam logic [CFG_W-1:0] PAGES_RESET = 7'd64;

  typedef struct packed {
    logic       io;
    logic [7:0] page;
  } map_entry_t;

endpackage

`default_nettype wire

### src/smp_page_mmu_with_bus_lock_core.sv
// Paged MMU for several 8-bit CPUs: window maps, page ownership, bus lock, page RAM.
// Depends on spmmu_pkg.
//
// A transaction is taken when start is high and busy is low. A tick, a port access,
// a memory write or any access that resolves in the map (device window, missing
// page, owner conflict) goes through the window map read and then the decision.
// A memory read adds the page RAM read after the decision. Each result
// shows for exactly one cycle with done high; there is no back-pressure, so the
// receiver must take it then. After reset the block is busy while all PAGE_COUNT*4096
// bytes of page RAM are zeroed one byte a cycle; cfg_we writes are taken at any
// time, but are meant only while the block is idle.
`default_nettype none

module smp_page_mmu_with_bus_lock_core #(
  parameter int CPU_COUNT  = spmmu_pkg::CPU_COUNT_DEF,
  parameter int PAGE_COUNT = spmmu_pkg::PAGE_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type,
  input  wire logic [spmmu_pkg::CPU_ID_W-1:0]    cpu_id,
  input  wire logic [spmmu_pkg::ADDR_W-1:0]      address,
  input  wire logic                              is_write,
  input  wire logic                              opcode_fetch,
  input  wire logic [spmmu_pkg::BYTE_W-1:0]      write_byte,
  input  wire logic                              cfg_we,
  input  wire logic [spmmu_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                                   done,
  output logic [spmmu_pkg::BYTE_W-1:0]           read_byte,
  output logic                                   wait_retry,
  output logic                                   claimed,
  output logic                                   device_access,
  output logic [3:0]                             device_slot,
  output logic [spmmu_pkg::ADDR_W-1:0]           device_address
);

  localparam int MAP_DEPTH = CPU_COUNT * spmmu_pkg::WIN_PER_CPU;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int PAGE_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int RAM_AW    = PAGE_W + spmmu_pkg::OFFSET_W;
  localparam int RAM_DEPTH = PAGE_COUNT * (2 ** spmmu_pkg::OFFSET_W);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAP   = 2'd1;
  localparam logic [1:0] S_RAM   = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  // ---------------------------------------------------------------- state
  logic [1:0]        state, state_next;
  logic [RAM_AW-1:0] clear_cnt, clear_cnt_next;
  logic [spmmu_pkg::CFG_W-1:0] pages_in_use;

  // captured transaction
  logic [1:0]                       type_q;
  logic [spmmu_pkg::CPU_ID_W-1:0]   cpu_q;
  logic [spmmu_pkg::ADDR_W-1:0]     addr_q;
  logic                             wr_q;
  logic                             fetch_q;
  logic [spmmu_pkg::BYTE_W-1:0]     wdata_q;

  // window map memory plus per-entry valid bits (unwritten entries read as zero)
  spmmu_pkg::map_entry_t map_mem [MAP_DEPTH];
  spmmu_pkg::map_entry_t map_rd;
  logic                  map_rd_valid;
  logic [MAP_DEPTH-1:0]  map_valid;
  logic                  map_we;
  logic [MAP_AW-1:0]     map_raddr;
  spmmu_pkg::map_entry_t map_wentry;
  spmmu_pkg::map_entry_t map_entry;

  // page RAM
  logic [7:0]        page_ram [RAM_DEPTH];
  logic [7:0]        ram_q;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;

  // ownership: one owned bit per page, one ownership lane per CPU
  logic [PAGE_COUNT-1:0] owned, owned_next;
  logic [PAGE_COUNT-1:0] own_mask [CPU_COUNT];
  logic [PAGE_COUNT-1:0] own_mask_next [CPU_COUNT];
  logic                  lock_valid, lock_valid_next;
  logic [spmmu_pkg::CPU_ID_W-1:0] lock_cpu, lock_cpu_next;
  logic [CPU_COUNT-1:0]  prefix, prefix_next;

  // result
  logic                             done_next, wait_next, claimed_next, dev_next;
  logic [spmmu_pkg::BYTE_W-1:0]     rd_next;
  logic [3:0]                       slot_next;
  logic [spmmu_pkg::ADDR_W-1:0]     daddr_next;

  // derived
  logic                  cpu_ok;
  logic [PAGE_W-1:0]     page_idx;
  logic                  page_live;
  logic                  page_mine;
  logic                  prefix_mine;
  logic [PAGE_COUNT-1:0] lock_mask;
  logic [3:0]            win_sel;

  assign busy = (state != S_IDLE);

  // map read address is taken from the ports at accept
  always_comb begin
    win_sel   = (req_type == spmmu_pkg::REQ_IO) ? address[11:8] : address[15:12];
    map_raddr = MAP_AW'(int'(cpu_id) * spmmu_pkg::WIN_PER_CPU + int'(win_sel));
  end

  always_comb begin
    map_entry   = map_rd_valid ? map_rd : '0;
    cpu_ok      = (int'(cpu_q) < CPU_COUNT);
    page_idx    = map_entry.page[PAGE_W-1:0];
    page_live   = (9'(map_entry.page) < 9'(pages_in_use)) &&
                  (int'(map_entry.page) < PAGE_COUNT);
    page_mine   = 1'b0;
    prefix_mine = 1'b0;
    lock_mask   = '0;
    for (int c = 0; c < CPU_COUNT; c++) begin
      if (int'(cpu_q) == c) begin
        page_mine   = own_mask[c][page_idx];
        prefix_mine = prefix[c];
      end
      if (int'(lock_cpu) == c) lock_mask = own_mask[c];
    end
  end

  always_comb begin
    state_next      = state;
    clear_cnt_next  = clear_cnt;
    owned_next      = owned;
    for (int c = 0; c < CPU_COUNT; c++) own_mask_next[c] = own_mask[c];
    lock_valid_next = lock_valid;
    lock_cpu_next   = lock_cpu;
    prefix_next     = prefix;
    done_next       = 1'b0;
    rd_next         = '0;
    wait_next       = 1'b0;
    claimed_next    = 1'b0;
    dev_next        = 1'b0;
    slot_next       = '0;
    daddr_next      = '0;
    map_we          = 1'b0;
    map_wentry      = '{io: addr_q[14], page: wdata_q};
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_addr        = {page_idx, addr_q[spmmu_pkg::OFFSET_W-1:0]};
    ram_wdata       = wdata_q;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clear_cnt;
        ram_wdata = '0;
        if (clear_cnt == RAM_AW'(RAM_DEPTH - 1)) state_next = S_IDLE;
        else clear_cnt_next = clear_cnt + 1'b1;
      end

      S_IDLE: begin
        if (start) state_next = S_MAP;
      end

      S_MAP: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (type_q)
          spmmu_pkg::REQ_TICK: begin
            // free every live page not owned by the lock holder
            for (int i = 0; i < PAGE_COUNT; i++) begin
              if (i < int'(pages_in_use) && !(lock_valid && lock_mask[i]))
                owned_next[i] = 1'b0;
            end
          end
          spmmu_pkg::REQ_IO: begin
            if (!cpu_ok) begin
              rd_next = wr_q ? '0 : spmmu_pkg::BYTE_ONES;
            end else if (addr_q[7:0] != spmmu_pkg::MAP_PORT) begin
              rd_next = wr_q ? '0 : spmmu_pkg::BYTE_ONES;
            end else begin
              claimed_next = 1'b1;
              if (wr_q) begin
                map_we = !addr_q[15];
              end else begin
                case (addr_q[15:12])
                  spmmu_pkg::CMD_PAGE: rd_next = map_entry.page;
                  spmmu_pkg::CMD_FLAG: rd_next = spmmu_pkg::FLAG_BASE |
                                                 {6'd0, map_entry.io, 1'b0};
                  spmmu_pkg::CMD_CPU:  rd_next = 8'(cpu_q);
                  default:             rd_next = spmmu_pkg::BYTE_ONES;
                endcase
              end
            end
          end
          spmmu_pkg::REQ_MEM: begin
            if (!cpu_ok) begin
              rd_next = wr_q ? '0 : spmmu_pkg::BYTE_ONES;
            end else begin
              claimed_next = 1'b1;
              if (map_entry.io) begin
                rd_next    = wr_q ? '0 : spmmu_pkg::BYTE_ONES;
                dev_next   = 1'b1;
                slot_next  = map_entry.page[7:4];
                daddr_next = {map_entry.page[3:0], addr_q[spmmu_pkg::OFFSET_W-1:0]};
              end else if (!page_live) begin
                rd_next = wr_q ? '0 : spmmu_pkg::BYTE_ONES;
              end else if (owned[page_idx] && !page_mine) begin
                wait_next = 1'b1;
              end else begin
                owned_next[page_idx] = 1'b1;
                for (int c = 0; c < CPU_COUNT; c++)
                  own_mask_next[c][page_idx] = (int'(cpu_q) == c);
                if (wr_q) begin
                  ram_we = 1'b1;
                  if (lock_valid && lock_cpu == cpu_q) lock_valid_next = 1'b0;
                end else begin
                  ram_re     = 1'b1;
                  done_next  = 1'b0;
                  state_next = S_RAM;
                end
              end
            end
          end
          default: ;
        endcase
      end

      S_RAM: begin
        state_next   = S_IDLE;
        done_next    = 1'b1;
        claimed_next = 1'b1;
        rd_next      = ram_q;
        if (ram_q == spmmu_pkg::PREFIX_BYTE) begin
          if (prefix_mine) begin
            if (lock_valid && lock_cpu != cpu_q) begin
              wait_next = 1'b1;
              rd_next   = '0;
            end else begin
              lock_valid_next = 1'b1;
              lock_cpu_next   = cpu_q;
            end
          end else if (fetch_q) begin
            for (int c = 0; c < CPU_COUNT; c++)
              if (int'(cpu_q) == c) prefix_next[c] = 1'b1;
          end
        end else begin
          for (int c = 0; c < CPU_COUNT; c++)
            if (int'(cpu_q) == c) prefix_next[c] = 1'b0;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // write address of the map is the captured window, same form as the read
  function automatic logic [MAP_AW-1:0] map_waddr();
    return MAP_AW'(int'(cpu_q) * spmmu_pkg::WIN_PER_CPU + int'(addr_q[11:8]));
  endfunction

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_cnt    <= '0;
      pages_in_use <= spmmu_pkg::PAGES_RESET;
      map_valid    <= '0;
      owned        <= '0;
      lock_valid   <= 1'b0;
      prefix       <= '0;
      done         <= 1'b0;
    end else begin
      state      <= state_next;
      clear_cnt  <= clear_cnt_next;
      owned      <= owned_next;
      lock_valid <= lock_valid_next;
      prefix     <= prefix_next;
      done       <= done_next;
      if (cfg_we) pages_in_use <= cfg_wdata;
      if (map_we) map_valid[map_waddr()] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    lock_cpu <= lock_cpu_next;
    for (int c = 0; c < CPU_COUNT; c++) own_mask[c] <= own_mask_next[c];
    read_byte      <= rd_next;
    wait_retry     <= wait_next;
    claimed        <= claimed_next;
    device_access  <= dev_next;
    device_slot    <= slot_next;
    device_address <= daddr_next;
    if (state == S_IDLE && start) begin
      type_q       <= req_type;
      cpu_q        <= cpu_id;
      addr_q       <= address;
      wr_q         <= is_write;
      fetch_q      <= opcode_fetch;
      wdata_q      <= write_byte;
      map_rd_valid <= map_valid[map_raddr];
    end
  end

  // window map memory: read at accept, written in the decide cycle
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr()] <= map_wentry;
    if (state == S_IDLE && start) map_rd <= map_mem[map_raddr];
  end

  // page RAM: one port, read data registered
  always_ff @(posedge clk) begin
    if (ram_we) page_ram[ram_addr] <= ram_wdata;
    if (ram_re) ram_q <= page_ram[ram_addr];
  end

  // ---------------------------------------------------------------- checks
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_MAP || $past(state) == S_RAM))
    else $error("result strobe without a transaction in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_wait_clean: assert property (@(posedge clk) disable iff (rst)
    (done && wait_retry) |-> (claimed && read_byte == '0 && !device_access))
    else $error("retry result carries data");

  a_device_claimed: assert property (@(posedge clk) disable iff (rst)
    (done && device_access) |-> (claimed && !wait_retry))
    else $error("device access not claimed");

  a_ram_read_before: assert property (@(posedge clk) disable iff (rst)
    (state == S_RAM) |-> ($past(state) == S_MAP && !$past(done_next)))
    else $error("RAM result stage entered without a RAM read");

endmodule

`default_nettype wire
